@@ rtl/core/wfr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, protocol codes and the CRC-8 fold of the frame receiver.
// No dependencies.
package wfr_pkg;

  localparam logic [7:0] FEND_CODE   = 8'hC0;
  localparam logic [7:0] FESC_CODE   = 8'hDB;
  localparam logic [7:0] TFEND_CODE  = 8'hDC;
  localparam logic [7:0] TFESC_CODE  = 8'hDD;
  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [7:0] CMD_TOP_BIT = 8'h80;

  localparam logic [15:0] MAX_LENGTH_RST = 16'd256;
  localparam logic [7:0]  CRC_SEED_RST   = 8'hDE;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    KIND_FEND   = 2'd0,
    KIND_SKIP   = 2'd1,
    KIND_BADESC = 2'd2,
    KIND_BYTE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_DATA  = 2'd1,
    ST_GOOD  = 2'd2,
    ST_ERROR = 2'd3
  } status_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [15:0] byte_index;
    logic [7:0]  data_byte;
    logic [6:0]  command;
    status_e     status;
  } result_t;

  typedef struct packed {
    logic [15:0] max_length;
    logic [7:0]  crc_seed;
  } cfg_t;

  function automatic logic [7:0] crc8_fold(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = b;
    for (int i = 0; i < 8; i++) begin
      if ((c[0] ^ d[0]) == 1'b1) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

@@ rtl/core/wfr_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts raw bytes, unstuffs escapes and classifies each item.
// Depends on wfr_pkg.
module wfr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          q_full_i,
  output logic          push_o,
  output wfr_pkg::item_t push_item_o
);

  logic [7:0] prev_q;
  logic [7:0] prev_d;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;
  assign prev_d     = accept ? in_byte_i : prev_q;

  always_comb begin
    push_item_o.kind = wfr_pkg::KIND_BYTE;
    push_item_o.data = in_byte_i;
    if (in_byte_i == wfr_pkg::FEND_CODE) begin
      push_item_o.kind = wfr_pkg::KIND_FEND;
    end else if (prev_q == wfr_pkg::FESC_CODE) begin
      if (in_byte_i == wfr_pkg::TFESC_CODE) begin
        push_item_o.data = wfr_pkg::FESC_CODE;
      end else if (in_byte_i == wfr_pkg::TFEND_CODE) begin
        push_item_o.data = wfr_pkg::FEND_CODE;
      end else begin
        push_item_o.kind = wfr_pkg::KIND_BADESC;
      end
    end else if (in_byte_i == wfr_pkg::FESC_CODE) begin
      push_item_o.kind = wfr_pkg::KIND_SKIP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

@@ rtl/core/wfr_fifo.sv @@
`timescale 1ns / 1ps
// Two-entry queue of classified items between front and back end.
// Depends on wfr_pkg.
module wfr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wfr_pkg::item_t push_item_i,
  input  logic           pop_i,
  output wfr_pkg::item_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  wfr_pkg::item_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != 2'd2) else $error("push into full queue");
`endif

endmodule

@@ rtl/core/wfr_back.sv @@
`timescale 1ns / 1ps
// Back end: frame state machine, CRC-8 check and registered result output.
// Depends on wfr_pkg.
module wfr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wfr_pkg::cfg_t    cfg_i,
  input  logic             q_empty_i,
  input  wfr_pkg::item_t   head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output wfr_pkg::result_t out_res_o
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_CMD    = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_DATA   = 3'd4
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [7:0]       crc_q, crc_d;
  logic [6:0]       cmd_q, cmd_d;
  logic [15:0]      len_q, len_d;
  logic [15:0]      cnt_q, cnt_d;
  logic             valid_q, valid_d;
  wfr_pkg::result_t res_q, res;
  logic [7:0]       b;
  logic [15:0]      len_full;

  assign pop_o       = !q_empty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;
  assign b           = head_i.data;
  assign len_full    = {len_q[15:8], b};

  always_comb begin
    phase_d = phase_q;
    crc_d   = crc_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    res     = '{byte_index: '0, data_byte: '0, command: '0, status: wfr_pkg::ST_NONE};
    case (head_i.kind)
      wfr_pkg::KIND_FEND: begin
        phase_d = PH_CMD;
        crc_d   = wfr_pkg::crc8_fold(cfg_i.crc_seed, wfr_pkg::FEND_CODE);
      end
      wfr_pkg::KIND_BADESC: begin
        if (phase_q inside {PH_CMD, PH_LEN_HI, PH_LEN_LO, PH_DATA}) begin
          phase_d    = PH_IDLE;
          res.status = wfr_pkg::ST_ERROR;
        end
      end
      wfr_pkg::KIND_BYTE: begin
        case (phase_q)
          PH_CMD: begin
            if ((b & wfr_pkg::CMD_TOP_BIT) != 8'd0) begin
              phase_d    = PH_IDLE;
              res.status = wfr_pkg::ST_ERROR;
            end else begin
              cmd_d   = b[6:0];
              crc_d   = wfr_pkg::crc8_fold(crc_q, b);
              phase_d = PH_LEN_HI;
            end
          end
          PH_LEN_HI: begin
            len_d   = {b, 8'd0};
            crc_d   = wfr_pkg::crc8_fold(crc_q, b);
            phase_d = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len_d = len_full;
            if (len_full > cfg_i.max_length) begin
              phase_d    = PH_IDLE;
              res.status = wfr_pkg::ST_ERROR;
            end else begin
              crc_d   = wfr_pkg::crc8_fold(crc_q, b);
              cnt_d   = '0;
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            if (cnt_q < len_q) begin
              res.status     = wfr_pkg::ST_DATA;
              res.data_byte  = b;
              res.byte_index = cnt_q;
              cnt_d          = cnt_q + 16'd1;
              crc_d          = wfr_pkg::crc8_fold(crc_q, b);
            end else if (b != crc_q) begin
              phase_d    = PH_IDLE;
              res.status = wfr_pkg::ST_ERROR;
            end else begin
              phase_d     = PH_IDLE;
              res.status  = wfr_pkg::ST_GOOD;
              res.command = cmd_q;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      crc_q   <= '0;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
      res_q   <= '0;
    end else begin
      valid_q <= valid_d;
      if (pop_o) begin
        phase_q <= phase_d;
        crc_q   <= crc_d;
        cmd_q   <= cmd_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
        res_q   <= res;
      end
    end
  end

`ifndef ASSERT_OFF
  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (res.status == wfr_pkg::ST_ERROR || res.status == wfr_pkg::ST_GOOD))
    |=> phase_q == PH_IDLE) else $error("frame end did not return to idle");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> cnt_q <= len_q) else $error("data count past length");
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_res_o)))
    else $error("result changed while stalled");
`endif

endmodule

@@ rtl/core/wake_frame_receiver.sv @@
`timescale 1ns / 1ps
// A byte accepted on the slave side is written into the queue, then popped into the registered master-side result.
// Throughput: one byte per cycle while the queue is not full; the two-entry queue and output register decouple stalls.
// The CRC-8 fold and frame state update are combinational and are registered when an item is popped.
// Reset: empty queue, no result pending, waiting for frame start,
// max_length = 256 and crc_seed = 0xDE.
module wake_frame_receiver (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [1:0] status, [8:2] command, [16:9] data_byte, [32:17] byte_index, [39:33] zero
  output logic [wfr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wfr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [wfr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [wfr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  wfr_pkg::cfg_t    cfg_q, cfg_d;
  wfr_pkg::item_t   push_item;
  wfr_pkg::item_t   head;
  wfr_pkg::result_t res;
  logic             push, pop, q_full, q_empty;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      if (paddr[2]) begin
        cfg_d.crc_seed = pwdata[7:0];
      end else begin
        cfg_d.max_length = pwdata[15:0];
      end
    end
    if (paddr[2]) begin
      prdata = {24'd0, cfg_q.crc_seed};
    end else begin
      prdata = {16'd0, cfg_q.max_length};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_length <= wfr_pkg::MAX_LENGTH_RST;
      cfg_q.crc_seed   <= wfr_pkg::CRC_SEED_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  wfr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  wfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {7'd0, res.byte_index, res.data_byte, res.command, res.status};

endmodule

@@ bench/tb_wake_frame_receiver.sv @@
`timescale 1ns / 1ps
// Self-checking bench for wake_frame_receiver: feeds stuffed serial frames, predicts every
// status item with its own frame decoder and CRC-8, and compares the results field by field.
// Depends on wfr_pkg and the wake_frame_receiver RTL.
module tb_wake_frame_receiver;

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_COMMAND  = 3'd1,
    PH_LEN_HIGH = 3'd2,
    PH_LEN_LOW  = 3'd3,
    PH_PAYLOAD  = 3'd4
  } rx_phase_e;

  typedef enum {
    FAULT_NONE,
    FAULT_CRC,
    FAULT_CMD_TOP,
    FAULT_BAD_ESCAPE,
    FAULT_TOO_LONG,
    FAULT_TRUNCATED
  } fault_e;

  localparam logic [wfr_pkg::CFG_ADDR_W-1:0] ADDR_MAX_LENGTH = 3'd0;
  localparam logic [wfr_pkg::CFG_ADDR_W-1:0] ADDR_CRC_SEED   = 3'd4;
  localparam int PHASE_ITEMS  = 240;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_LIMIT  = 50;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata = '0;  // [7:0] rx_byte
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // [1:0] status, [8:2] command, [16:9] data_byte, [32:17] byte_index, [39:33] zero
  logic [wfr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [wfr_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [wfr_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [wfr_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  logic [7:0]       line_bytes[$];
  wfr_pkg::result_t expected_events[$];
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               mismatch_count = 0;

  logic [15:0] cfg_max_length = wfr_pkg::MAX_LENGTH_RST;
  logic [7:0]  cfg_crc_seed = wfr_pkg::CRC_SEED_RST;

  rx_phase_e   rx_phase = PH_HUNT;
  logic [7:0]  prev_raw = '0;
  logic [7:0]  frame_crc = '0;
  logic [6:0]  frame_cmd = '0;
  logic [15:0] frame_len = '0;
  logic [15:0] data_count = '0;

  wake_frame_receiver uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] dallas_crc8(logic [7:0] crc, logic [7:0] value);
    logic feedback;
    for (int k = 0; k < 8; k++) begin
      feedback = crc[0] ^ value[k];
      crc = {1'b0, crc[7:1]};
      if (feedback) begin
        crc = crc ^ wfr_pkg::CRC_POLY;
      end
    end
    return crc;
  endfunction

  task automatic decode_rx_byte(input logic [7:0] raw);
    wfr_pkg::result_t r;
    logic [7:0]       b;
    logic [7:0]       last_raw;
    logic             take;
    r = '0;
    r.status = wfr_pkg::ST_NONE;
    b = raw;
    take = 1'b1;
    if (raw == wfr_pkg::FEND_CODE) begin
      prev_raw = raw;
      rx_phase = PH_COMMAND;
      frame_crc = dallas_crc8(cfg_crc_seed, raw);
    end else if (rx_phase != PH_HUNT) begin
      last_raw = prev_raw;
      prev_raw = raw;
      if (last_raw == wfr_pkg::FESC_CODE) begin
        if (raw == wfr_pkg::TFESC_CODE) begin
          b = wfr_pkg::FESC_CODE;
        end else if (raw == wfr_pkg::TFEND_CODE) begin
          b = wfr_pkg::FEND_CODE;
        end else begin
          rx_phase = PH_HUNT;
          r.status = wfr_pkg::ST_ERROR;
          take = 1'b0;
        end
      end else if (raw == wfr_pkg::FESC_CODE) begin
        take = 1'b0;
      end
      if (take) begin
        case (rx_phase)
          PH_COMMAND: begin
            if ((b & wfr_pkg::CMD_TOP_BIT) != 8'h00) begin
              rx_phase = PH_HUNT;
              r.status = wfr_pkg::ST_ERROR;
            end else begin
              frame_cmd = b[6:0];
              frame_crc = dallas_crc8(frame_crc, b);
              rx_phase = PH_LEN_HIGH;
            end
          end
          PH_LEN_HIGH: begin
            frame_len = {b, 8'h00};
            frame_crc = dallas_crc8(frame_crc, b);
            rx_phase = PH_LEN_LOW;
          end
          PH_LEN_LOW: begin
            frame_len = {frame_len[15:8], b};
            if (frame_len > cfg_max_length) begin
              rx_phase = PH_HUNT;
              r.status = wfr_pkg::ST_ERROR;
            end else begin
              frame_crc = dallas_crc8(frame_crc, b);
              data_count = '0;
              rx_phase = PH_PAYLOAD;
            end
          end
          default: begin
            if (data_count < frame_len) begin
              r.status = wfr_pkg::ST_DATA;
              r.data_byte = b;
              r.byte_index = data_count;
              data_count = data_count + 16'd1;
              frame_crc = dallas_crc8(frame_crc, b);
            end else if (b != frame_crc) begin
              rx_phase = PH_HUNT;
              r.status = wfr_pkg::ST_ERROR;
            end else begin
              rx_phase = PH_HUNT;
              r.status = wfr_pkg::ST_GOOD;
              r.command = frame_cmd;
            end
          end
        endcase
      end
    end
    expected_events.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_result(input logic [wfr_pkg::OUT_DATA_W-1:0] word);
    wfr_pkg::result_t got;
    wfr_pkg::result_t want;
    got = wfr_pkg::result_t'(word[$bits(wfr_pkg::result_t)-1:0]);
    if (expected_events.size() == 0) begin
      report_mismatch("unexpected item", word[31:0], '0);
      return;
    end
    want = expected_events.pop_front();
    if (got.status != want.status) begin
      report_mismatch("status", 32'(got.status), 32'(want.status));
    end
    if (got.command != want.command) begin
      report_mismatch("command", 32'(got.command), 32'(want.command));
    end
    if (got.data_byte != want.data_byte) begin
      report_mismatch("data_byte", 32'(got.data_byte), 32'(want.data_byte));
    end
    if (got.byte_index != want.byte_index) begin
      report_mismatch("byte_index", 32'(got.byte_index), 32'(want.byte_index));
    end
    if (word[wfr_pkg::OUT_DATA_W-1:$bits(wfr_pkg::result_t)] != '0) begin
      report_mismatch("padding", 32'(word[wfr_pkg::OUT_DATA_W-1:$bits(wfr_pkg::result_t)]),
                      '0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_rx_byte(s_axis_tdata);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (line_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= line_bytes.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic apb_write(input logic [wfr_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (line_bytes.size() != 0 || s_axis_tvalid || expected_events.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Build one frame, stuff it onto the line and apply the requested fault.
  task automatic queue_frame(input logic [6:0] cmd, input int length, input fault_e fault);
    logic [7:0] body[$];
    logic [7:0] crc;
    logic [7:0] v;
    int         cut;
    int         spot;
    body.push_back((fault == FAULT_CMD_TOP) ? {1'b1, cmd} : {1'b0, cmd});
    body.push_back(length[15:8]);
    body.push_back(length[7:0]);
    for (int i = 0; i < ((fault == FAULT_TOO_LONG) ? 3 : length); i++) begin
      case ($urandom_range(11))
        0: v = wfr_pkg::FEND_CODE;
        1: v = wfr_pkg::FESC_CODE;
        2: v = wfr_pkg::TFEND_CODE;
        3: v = wfr_pkg::TFESC_CODE;
        default: v = 8'($urandom_range(255));
      endcase
      body.push_back(v);
    end
    crc = dallas_crc8(cfg_crc_seed, wfr_pkg::FEND_CODE);
    foreach (body[i]) crc = dallas_crc8(crc, body[i]);
    if (fault == FAULT_CRC) crc = crc ^ 8'($urandom_range(1, 255));
    body.push_back(crc);
    cut = (fault == FAULT_TRUNCATED) ? $urandom_range(0, body.size() - 1) : body.size();
    spot = (fault == FAULT_BAD_ESCAPE) ? $urandom_range(0, body.size() - 1) : -1;
    line_bytes.push_back(wfr_pkg::FEND_CODE);
    for (int i = 0; i < cut; i++) begin
      if (i == spot) begin
        do begin
          v = 8'($urandom_range(255));
        end while (v == wfr_pkg::TFEND_CODE || v == wfr_pkg::TFESC_CODE ||
                   v == wfr_pkg::FEND_CODE);
        line_bytes.push_back(wfr_pkg::FESC_CODE);
        line_bytes.push_back(v);
      end
      if (body[i] == wfr_pkg::FEND_CODE) begin
        line_bytes.push_back(wfr_pkg::FESC_CODE);
        line_bytes.push_back(wfr_pkg::TFEND_CODE);
      end else if (body[i] == wfr_pkg::FESC_CODE) begin
        line_bytes.push_back(wfr_pkg::FESC_CODE);
        line_bytes.push_back(wfr_pkg::TFESC_CODE);
      end else begin
        line_bytes.push_back(body[i]);
      end
    end
  endtask

  initial begin
    logic [15:0] max_set[7];
    logic [7:0]  seed_set[7];
    int          send_set[7];
    int          stall_set[7];
    fault_e      fault;
    int          pick;
    int          length;
    int          cap;

    max_set   = '{16'd0, 16'hFFFF, 16'h00DA, 16'hBFFF, 16'd5, 16'd256, 16'd0};
    seed_set  = '{8'h00, 8'hFF, 8'h00, 8'hDE, 8'h00, 8'h00, 8'h00};
    send_set  = '{56, 0, 12, 0, 56, 0, 12};
    stall_set = '{0, 56, 12, 0, 0, 56, 12};
    seed_set[2] = 8'($urandom_range(255));
    seed_set[4] = 8'($urandom_range(255));
    seed_set[5] = 8'($urandom_range(255));
    seed_set[6] = 8'($urandom_range(255));
    max_set[6] = 16'($urandom_range(20));

    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle noise, extreme commands, each error path, reset config.
    line_bytes.push_back(8'h00);
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(wfr_pkg::FESC_CODE);
    queue_frame(7'h00, 0, FAULT_CRC);
    queue_frame(7'h7F, 1, FAULT_NONE);
    line_bytes.push_back(wfr_pkg::FEND_CODE);
    line_bytes.push_back(8'h80);
    line_bytes.push_back(wfr_pkg::FEND_CODE);
    line_bytes.push_back(wfr_pkg::FESC_CODE);
    line_bytes.push_back(wfr_pkg::FESC_CODE);
    line_bytes.push_back(wfr_pkg::FEND_CODE);
    line_bytes.push_back(8'h01);
    line_bytes.push_back(8'h01);
    line_bytes.push_back(8'h01);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      apb_write(ADDR_MAX_LENGTH, {16'h0000, max_set[p]});
      apb_write(ADDR_CRC_SEED, {24'h000000, seed_set[p]});
      cfg_max_length = max_set[p];
      cfg_crc_seed = seed_set[p];
      send_idle_pct = send_set[p];
      recv_stall_pct = stall_set[p];
      while (line_bytes.size() < PHASE_ITEMS) begin
        if ($urandom_range(7) == 0) begin
          repeat ($urandom_range(1, 3)) line_bytes.push_back(8'($urandom_range(255)));
        end
        pick = $urandom_range(99);
        if (pick < 6) fault = FAULT_CRC;
        else if (pick < 11) fault = FAULT_CMD_TOP;
        else if (pick < 16) fault = FAULT_BAD_ESCAPE;
        else if (pick < 22) fault = FAULT_TOO_LONG;
        else if (pick < 27) fault = FAULT_TRUNCATED;
        else fault = FAULT_NONE;
        if (fault == FAULT_TOO_LONG && cfg_max_length == 16'hFFFF) fault = FAULT_CRC;
        pick = $urandom_range(99);
        if (fault == FAULT_TOO_LONG) begin
          length = (pick < 50) ? cfg_max_length + 1 :
                   $urandom_range(65535, cfg_max_length + 1);
        end else if (pick < 3 && cfg_max_length >= 256) begin
          cap = (cfg_max_length < 280) ? cfg_max_length : 280;
          length = $urandom_range(256, cap);
        end else if (pick < 15 && cfg_max_length <= 40) begin
          length = int'(cfg_max_length);
        end else begin
          cap = (cfg_max_length < 8) ? cfg_max_length : 8;
          length = $urandom_range(0, cap);
        end
        queue_frame(7'($urandom_range(127)), length, fault);
      end
      // close the phase with a clean frame so the receiver is back in hunt
      queue_frame(7'($urandom_range(127)), 0, FAULT_NONE);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("tb_wake_frame_receiver passed");
    end else begin
      $display("tb_wake_frame_receiver failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_wake_frame_receiver failed");
    $finish;
  end

endmodule
